// ===== sv/clipped_glyph_row_rasterizer_core_macros.svh =====
// ----------------------------------------------------------------------------
// clipped glyph row rasterizer assertion macros
// shorthand for clocked implication checks with a synchronous reset
// ----------------------------------------------------------------------------
`ifndef CLIPPED_GLYPH_ROW_RASTERIZER_CORE_MACROS_SVH
`define CLIPPED_GLYPH_ROW_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication
`define CGR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CGR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cgr_pkg.sv =====
// ----------------------------------------------------------------------------
// cgr_pkg
// shared types and constants of the clipped glyph row rasterizer
// ----------------------------------------------------------------------------
package cgr_pkg;

   localparam int CGR_STORE_WORDS = 4096;
   localparam int CGR_MAX_ROWS    = 32;
   localparam int CGR_CSR_AW      = 5;

   // request actions
   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_SET_PEN = 2'd1;
   localparam logic [1:0] ACT_DRAW    = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_FIRST_CODE    = 3'd0;
   localparam logic [2:0] CSR_LAST_CODE     = 3'd1;
   localparam logic [2:0] CSR_GLYPH_HEIGHT  = 3'd2;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_INK_COLOR     = 3'd5;
   localparam logic [2:0] CSR_PAPER_COLOR   = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_REDUCE,
      ST_WRITE,
      ST_WIDTH,
      ST_SETUP,
      ST_ROW
   } cgr_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } cgr_mem_ctl_type;

endpackage

// ===== sv/clipped_glyph_row_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// clipped glyph row rasterizer core
// Draws proportional glyphs from a word-loaded store as clipped row words.
// Requests: start with req_* fields, accepted when start is high and busy
// low. Action load writes one store word, set pen moves the pen, draw emits
// one result word per glyph row, at most MAX_ROWS (or a single word for an
// out-of-range code or a zero-height font). Results appear on rsp_* for one
// cycle with rsp_valid high; rsp_last marks the final word of a draw. The
// receiver cannot stall the block, so results are never held back.
// Sequence: set pen, an unused action and an out-of-range draw keep the block
// idle, the out-of-range result following in the next cycle. A load runs R
// reduce steps and then a write; an in-range draw runs scale, R reduce steps,
// width and setup, then one row state per row, where
// R = 17 - clog2(STORE_WORDS) (5 at 4096 words) is the number of
// conditional-subtract steps of the shared address reduction unit. Rows
// then stream at one per cycle, paced by the store read port.
// Registers sit on the APB port at byte addresses 4*i. Reset clears the
// sequencer and the pen and loads the registers with their defaults; store contents are left undefined.
// ----------------------------------------------------------------------------
module clipped_glyph_row_rasterizer_core
   import cgr_pkg::*;
#(
   parameter int STORE_WORDS = CGR_STORE_WORDS,
   parameter int MAX_ROWS    = CGR_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [11:0]           req_store_address,
   input  logic [31:0]           req_store_word,
   input  logic signed [15:0]    req_pen_x_in,
   input  logic signed [15:0]    req_pen_y_in,
   input  logic [7:0]            req_char_code,
   output logic                  rsp_valid,
   output logic signed [15:0]    rsp_row_y,
   output logic signed [15:0]    rsp_row_x,
   output logic [30:0]           rsp_ink_bits,
   output logic [30:0]           rsp_visible_mask,
   output logic [4:0]            rsp_glyph_width,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CGR_CSR_AW-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW        = $clog2(STORE_WORDS);
   localparam int RED_STEPS = 17 - $clog2(STORE_WORDS);
   localparam int RCW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
   localparam int YW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RW        = $clog2(MAX_ROWS + 1);
   localparam logic [16:0] RED_TOP = 17'(STORE_WORDS * (2 ** (RED_STEPS - 1)));
   localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_WORDS - 1);

   function automatic logic [30:0] ones_below(input logic [4:0] n);
      logic [31:0] t;
      t = (32'd1 << n) - 32'd1;
      return t[30:0];
   endfunction

   function automatic logic [31:0] reverse32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[i] = v[31 - i];
      end
      return r;
   endfunction

   // sequencer and datapath registers
   cgr_state_type state_ff, state_in;
   logic          ret_draw_ff, ret_draw_in;
   logic [16:0]   red_val_ff, red_val_in;
   logic [16:0]   red_div_ff, red_div_in;
   logic [RCW-1:0] red_cnt_ff, red_cnt_in;
   logic [31:0]   word_ff, word_in;
   logic [7:0]    code_ff, code_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [4:0]    w_ff, w_in;
   logic [30:0]   range_mask_ff, range_mask_in;
   logic [30:0]   col_mask_ff, col_mask_in;
   logic [YW-1:0] yn_ff, yn_in;
   logic [RW-1:0] rows_ff, rows_in;
   logic [15:0]   pen_x_ff, pen_x_in;
   logic [15:0]   pen_y_ff, pen_y_in;

   // result word
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_row_y_ff, rsp_row_y_in;
   logic [15:0]   rsp_row_x_ff, rsp_row_x_in;
   logic [30:0]   rsp_ink_ff, rsp_ink_in;
   logic [30:0]   rsp_vis_ff, rsp_vis_in;
   logic [4:0]    rsp_w_ff, rsp_w_in;
   logic          rsp_last_ff, rsp_last_in;

   // configuration registers
   logic [7:0]    first_code_ff;
   logic [7:0]    last_code_ff;
   logic [5:0]    glyph_height_ff;
   logic [14:0]   screen_width_ff;
   logic [14:0]   screen_height_ff;
   logic [15:0]   ink_color_ff;
   logic [15:0]   paper_color_ff;

   // store interface
   cgr_mem_ctl_type mem_ctl;
   logic [AW-1:0]   mem_wr_addr;
   logic [AW-1:0]   mem_rd_addr;
   logic [31:0]     mem_rd_data;

   // helpers
   logic          in_range;
   logic          red_ge;
   logic [16:0]   red_step;
   logic [AW-1:0] addr_inc;
   logic [7:0]    code_off;
   logic [6:0]    stride;
   logic [14:0]   scale_prod;
   logic [15:0]   neg_px;
   logic [30:0]   lo_mask;
   logic [17:0]   hi_diff;
   logic [30:0]   hi_mask;
   logic [4:0]    w_sat;
   logic [5:0]    rows_full;
   logic [RW-1:0] rows_cur;
   logic          row_last;
   logic signed [16:0] row_sy;
   logic          row_on;
   logic [31:0]   ink_shift;
   logic [30:0]   ink_row;
   logic          csr_wr;

   assign in_range   = req_char_code inside {[first_code_ff:last_code_ff]};
   assign red_ge     = (red_val_ff >= red_div_ff);
   assign red_step   = red_ge ? (red_val_ff - red_div_ff) : red_val_ff;
   assign addr_inc   = (addr_ff == ADDR_LAST) ? '0 : addr_ff + AW'(1);
   assign code_off   = code_ff - first_code_ff;
   assign stride     = {1'b0, glyph_height_ff} + 7'd1;
   assign scale_prod = {7'd0, code_off} * {8'd0, stride};

   // horizontal clip range from the pen
   assign neg_px  = ~pen_x_ff + 16'd1;
   assign lo_mask = !pen_x_ff[15] ? '1 :
                    (neg_px >= 16'd31) ? '0 : ~ones_below(neg_px[4:0]);
   assign hi_diff = {3'd0, screen_width_ff} - {{2{pen_x_ff[15]}}, pen_x_ff};
   assign hi_mask = (hi_diff[17] || (hi_diff == 18'd0)) ? '0 :
                    (hi_diff >= 18'd31) ? '1 : ones_below(hi_diff[4:0]);

   assign w_sat     = (|mem_rd_data[31:5]) ? 5'd31 : mem_rd_data[4:0];
   assign rows_full = (glyph_height_ff > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : glyph_height_ff;
   assign rows_cur  = rows_full[RW-1:0];
   assign row_last  = (RW'(yn_ff) == rows_ff - RW'(1));

   assign row_sy    = {pen_y_ff[15], pen_y_ff} + 17'(yn_ff);
   assign row_on    = !row_sy[16] && (row_sy[15:0] < {1'b0, screen_height_ff});
   assign ink_shift = reverse32(mem_rd_data) >> (5'd31 - w_ff);
   assign ink_row   = ink_shift[30:0] & ones_below(w_ff);

   assign busy = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_LOAD: state_in = ST_REDUCE;
                  ACT_DRAW: state_in = in_range ? ST_SCALE : ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCALE:  state_in = ST_REDUCE;
         ST_REDUCE: begin
            if (red_cnt_ff == '0) begin
               state_in = ret_draw_ff ? ST_WIDTH : ST_WRITE;
            end
         end
         ST_WRITE:  state_in = ST_IDLE;
         ST_WIDTH:  state_in = ST_SETUP;
         ST_SETUP:  state_in = (rows_cur == '0) ? ST_IDLE : ST_ROW;
         ST_ROW:    state_in = row_last ? ST_IDLE : ST_ROW;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ret_draw_in   = ret_draw_ff;
      red_val_in    = red_val_ff;
      red_div_in    = red_div_ff;
      red_cnt_in    = red_cnt_ff;
      word_in       = word_ff;
      code_in       = code_ff;
      addr_in       = addr_ff;
      w_in          = w_ff;
      range_mask_in = range_mask_ff;
      col_mask_in   = col_mask_ff;
      yn_in         = yn_ff;
      rows_in       = rows_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      rsp_valid_in  = 1'b0;
      rsp_row_y_in  = rsp_row_y_ff;
      rsp_row_x_in  = rsp_row_x_ff;
      rsp_ink_in    = rsp_ink_ff;
      rsp_vis_in    = rsp_vis_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctl       = '0;
      mem_wr_addr   = red_val_ff[AW-1:0];
      mem_rd_addr   = addr_inc;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_LOAD: begin
                     ret_draw_in = 1'b0;
                     red_val_in  = 17'(req_store_address);
                     red_div_in  = RED_TOP;
                     red_cnt_in  = RCW'(RED_STEPS - 1);
                     word_in     = req_store_word;
                  end
                  ACT_SET_PEN: begin
                     pen_x_in = req_pen_x_in;
                     pen_y_in = req_pen_y_in;
                  end
                  ACT_DRAW: begin
                     ret_draw_in = 1'b1;
                     code_in     = req_char_code;
                     if (!in_range) begin
                        rsp_valid_in = 1'b1;
                        rsp_row_y_in = pen_y_ff;
                        rsp_row_x_in = pen_x_ff;
                        rsp_ink_in   = '0;
                        rsp_vis_in   = '0;
                        rsp_w_in     = '0;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCALE: begin
            red_val_in    = 17'(scale_prod);
            red_div_in    = RED_TOP;
            red_cnt_in    = RCW'(RED_STEPS - 1);
            range_mask_in = lo_mask & hi_mask;
         end
         ST_REDUCE: begin
            red_val_in = red_step;
            red_div_in = red_div_ff >> 1;
            red_cnt_in = red_cnt_ff - RCW'(1);
         end
         ST_WRITE: begin
            mem_ctl.wr_en = 1'b1;
         end
         ST_WIDTH: begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = red_val_ff[AW-1:0];
            addr_in       = red_val_ff[AW-1:0];
         end
         ST_SETUP: begin
            w_in          = w_sat;
            col_mask_in   = range_mask_ff & ones_below(w_sat);
            rows_in       = rows_cur;
            yn_in         = '0;
            mem_ctl.rd_en = 1'b1;
            addr_in       = addr_inc;
            if (rows_cur == '0) begin
               rsp_valid_in = 1'b1;
               rsp_row_y_in = pen_y_ff;
               rsp_row_x_in = pen_x_ff;
               rsp_ink_in   = '0;
               rsp_vis_in   = '0;
               rsp_w_in     = w_sat;
               rsp_last_in  = 1'b1;
               pen_x_in     = pen_x_ff + 16'(w_sat);
            end
         end
         ST_ROW: begin
            mem_ctl.rd_en = 1'b1;
            addr_in       = addr_inc;
            yn_in         = yn_ff + YW'(1);
            rsp_valid_in  = 1'b1;
            rsp_row_y_in  = pen_y_ff + 16'(yn_ff);
            rsp_row_x_in  = pen_x_ff;
            rsp_ink_in    = ink_row;
            rsp_vis_in    = row_on ? col_mask_ff : '0;
            rsp_w_in      = w_ff;
            rsp_last_in   = row_last;
            if (row_last) begin
               pen_x_in = pen_x_ff + 16'(w_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_draw_ff   <= ret_draw_in;
      red_val_ff    <= red_val_in;
      red_div_ff    <= red_div_in;
      red_cnt_ff    <= red_cnt_in;
      word_ff       <= word_in;
      code_ff       <= code_in;
      addr_ff       <= addr_in;
      w_ff          <= w_in;
      range_mask_ff <= range_mask_in;
      col_mask_ff   <= col_mask_in;
      yn_ff         <= yn_in;
      rows_ff       <= rows_in;
      rsp_row_y_ff  <= rsp_row_y_in;
      rsp_row_x_ff  <= rsp_row_x_in;
      rsp_ink_ff    <= rsp_ink_in;
      rsp_vis_ff    <= rsp_vis_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // configuration port
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_code_ff    <= 8'd32;
         last_code_ff     <= 8'd126;
         glyph_height_ff  <= 6'd16;
         screen_width_ff  <= 15'd64;
         screen_height_ff <= 15'd32;
         ink_color_ff     <= 16'hFFFF;
         paper_color_ff   <= 16'h0000;
      end else if (csr_wr) begin
         case (paddr[4:2])
            CSR_FIRST_CODE:    first_code_ff    <= pwdata[7:0];
            CSR_LAST_CODE:     last_code_ff     <= pwdata[7:0];
            CSR_GLYPH_HEIGHT:  glyph_height_ff  <= pwdata[5:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= pwdata[14:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= pwdata[14:0];
            CSR_INK_COLOR:     ink_color_ff     <= pwdata[15:0];
            CSR_PAPER_COLOR:   paper_color_ff   <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         CSR_FIRST_CODE:    prdata = {24'd0, first_code_ff};
         CSR_LAST_CODE:     prdata = {24'd0, last_code_ff};
         CSR_GLYPH_HEIGHT:  prdata = {26'd0, glyph_height_ff};
         CSR_SCREEN_WIDTH:  prdata = {17'd0, screen_width_ff};
         CSR_SCREEN_HEIGHT: prdata = {17'd0, screen_height_ff};
         CSR_INK_COLOR:     prdata = {16'd0, ink_color_ff};
         CSR_PAPER_COLOR:   prdata = {16'd0, paper_color_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;

   cgr_store #(
      .WORDS (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (word_ff),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_y        = rsp_row_y_ff;
   assign rsp_row_x        = rsp_row_x_ff;
   assign rsp_ink_bits     = rsp_ink_ff;
   assign rsp_visible_mask = rsp_vis_ff;
   assign rsp_glyph_width  = rsp_w_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== sv/cgr_store.sv =====
// ----------------------------------------------------------------------------
// cgr_store
// glyph store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module cgr_store
   import cgr_pkg::*;
#(
   parameter int WORDS = CGR_STORE_WORDS,
   localparam int AW = $clog2(WORDS)
) (
   input  logic            clock,
   input  cgr_mem_ctl_type mem_ctl,
   input  logic [AW-1:0]   wr_addr,
   input  logic [31:0]     wr_data,
   input  logic [AW-1:0]   rd_addr,
   output logic [31:0]     rd_data
);

   logic [31:0] mem_ff [WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cgr_checker.sv =====
// ----------------------------------------------------------------------------
// cgr_checker
// port-level checks of request and result word ordering
// ----------------------------------------------------------------------------
`include "clipped_glyph_row_rasterizer_core_macros.svh"

module cgr_checker
   import cgr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_last,
   input logic [4:0]  rsp_glyph_width,
   input logic [30:0] rsp_ink_bits,
   input logic [30:0] rsp_visible_mask
);

   `CGR_ASSERT_NEXT(a_set_pen_silent, clock, reset, start && !busy && req_action == ACT_SET_PEN, !rsp_valid, "set pen produced a result word")
   `CGR_ASSERT_NEXT(a_draw_answers, clock, reset, start && !busy && req_action == ACT_DRAW, busy || (rsp_valid && rsp_last && rsp_glyph_width == 5'd0), "draw neither busy nor rejected")
   `CGR_ASSERT_NEXT(a_rows_stream, clock, reset, rsp_valid && !rsp_last, rsp_valid, "gap inside a row burst")
   `CGR_ASSERT_NOW(a_zero_width_empty, clock, reset, rsp_valid && rsp_glyph_width == 5'd0, rsp_ink_bits == 31'd0 && rsp_visible_mask == 31'd0, "zero-width word carries bits")

endmodule

bind clipped_glyph_row_rasterizer_core cgr_checker u_cgr_checker (.*);
